>>> design/bfrv_pkg.sv
// Package for the brace frame receiver and validator.
// Holds item classes, status and register codes, key tables and shared types.
// No dependencies.
package bfrv_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 10;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int KEY_COUNT   = 4;
   localparam int KEY_IDX_W   = 2;
   localparam int PROG_W      = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [LEN_W-1:0] MIN_LEN_RESET = 10'd150;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd350;
   localparam logic [LEN_W-1:0] LEN_HARD_CAP  = 10'd1022;

   localparam logic [BYTE_W-1:0] CHAR_LOW   = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_HIGH  = 8'd126;
   localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h7B;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h7D;
   localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LEN = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN = 1'd1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_OPEN   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISS_KEY  = 2'd3;

   typedef enum logic [1:0] {
      CLS_BAD     = 2'd0,
      CLS_OPEN    = 2'd1,
      CLS_CLOSE   = 2'd2,
      CLS_CONTENT = 2'd3
   } cls_type;

   typedef struct packed {
      cls_type             cls;
      logic [BYTE_W-1:0]   data;
   } item_type;

   function automatic logic [PROG_W:0] key_len(input logic [KEY_IDX_W-1:0] k);
      case (k)
         2'd0:    key_len = 4'd6;
         2'd1:    key_len = 4'd5;
         2'd2:    key_len = 4'd6;
         default: key_len = 4'd8;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] key_char(input logic [KEY_IDX_W-1:0] k,
                                                  input logic [PROG_W-1:0] p);
      logic [BYTE_W-1:0] c;
      c = CHAR_QUOTE;
      case (k)
         2'd0: begin
            case (p)
               3'd1:    c = "t";
               3'd2:    c = "e";
               3'd3:    c = "m";
               3'd4:    c = "p";
               default: c = CHAR_QUOTE;
            endcase
         end
         2'd1: begin
            case (p)
               3'd1:    c = "h";
               3'd2:    c = "u";
               3'd3:    c = "m";
               default: c = CHAR_QUOTE;
            endcase
         end
         2'd2: begin
            case (p)
               3'd1:    c = "p";
               3'd2:    c = "r";
               3'd3:    c = "e";
               3'd4:    c = "s";
               default: c = CHAR_QUOTE;
            endcase
         end
         default: begin
            case (p)
               3'd1:    c = "u";
               3'd2:    c = "p";
               3'd3:    c = "t";
               3'd4:    c = "i";
               3'd5:    c = "m";
               3'd6:    c = "e";
               default: c = CHAR_QUOTE;
            endcase
         end
      endcase
      key_char = c;
   endfunction

endpackage

>>> design/brace_frame_receiver_validator.sv
// Channel   Direction  Ports                                       Moves
// req       in         req_valid/req_ready, req_rx_byte            one received byte
// rsp       out        rsp_valid/rsp_ready, length/status/valid    one closed frame result
// csr       in         csr_valid/csr_ready, csr_index, csr_wdata   min_len or max_len write
//
// One byte transaction per cycle while the queue has room; a '}' passes the queue, then its result is registered.
// The queue between classifier and back end holds QUEUE_DEPTH items; the result
// register frees in the cycle rsp_ready is seen, so a stalled rsp holds the back end only
// at a closing byte, and the input stalls once the queue fills behind it.
// Synchronous active-high reset: min_len 150, max_len 350, no frame open, queue empty.
// Top level: ties front end, item queue and back end. Depends on bfrv_pkg.
module brace_frame_receiver_validator #(
   parameter int QUEUE_DEPTH = bfrv_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bfrv_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bfrv_pkg::LEN_W-1:0]         rsp_frame_length,
   output logic [bfrv_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_frame_valid,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bfrv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bfrv_pkg::LEN_W-1:0]         csr_wdata
);

   logic               push_valid, push_ready;
   bfrv_pkg::item_type push_item;
   logic               pop_valid, pop_ready;
   bfrv_pkg::item_type pop_item;

   bfrv_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   bfrv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   bfrv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_length (rsp_frame_length),
      .rsp_status       (rsp_status),
      .rsp_frame_valid  (rsp_frame_valid)
   );

endmodule

>>> design/bfrv_front.sv
// Front end: accepts received bytes and classifies them.
// Depends on bfrv_pkg.
module bfrv_front (
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bfrv_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                         push_valid,
   input  logic                         push_ready,
   output bfrv_pkg::item_type           push_item
);

   always_comb begin
      push_item.data = req_rx_byte;
      if (req_rx_byte < bfrv_pkg::CHAR_LOW || req_rx_byte > bfrv_pkg::CHAR_HIGH) begin
         push_item.cls = bfrv_pkg::CLS_BAD;
      end else if (req_rx_byte == bfrv_pkg::CHAR_OPEN) begin
         push_item.cls = bfrv_pkg::CLS_OPEN;
      end else if (req_rx_byte == bfrv_pkg::CHAR_CLOSE) begin
         push_item.cls = bfrv_pkg::CLS_CLOSE;
      end else begin
         push_item.cls = bfrv_pkg::CLS_CONTENT;
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

>>> design/bfrv_queue.sv
// Short queue of classified items between front and back end.
// Depends on bfrv_pkg.
module bfrv_queue #(
   parameter int DEPTH = bfrv_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  bfrv_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output bfrv_pkg::item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bfrv_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_item;
      end
   end

endmodule

>>> design/bfrv_back.sv
// Back end: frame length tracking, key matchers, status and result register.
// Also holds the min_len and max_len registers. Depends on bfrv_pkg.
module bfrv_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  bfrv_pkg::item_type                 pop_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bfrv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bfrv_pkg::LEN_W-1:0]         csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bfrv_pkg::LEN_W-1:0]         rsp_frame_length,
   output logic [bfrv_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_frame_valid
);

   localparam int LW = bfrv_pkg::LEN_W;
   localparam int KC = bfrv_pkg::KEY_COUNT;
   localparam int PW = bfrv_pkg::PROG_W;

   logic [LW-1:0] min_len_ff, max_len_ff;
   logic [LW-1:0] open_length_ff, open_length_in;
   logic [PW-1:0] prog_ff [KC];
   logic [PW-1:0] prog_in [KC];
   logic [PW-1:0] feed_prog [KC];
   logic [KC-1:0] found_ff, found_in, feed_found;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]                 rsp_len_ff, rsp_len_in;
   logic [bfrv_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic          do_pop, is_close;
   logic [LW-1:0] close_len;

   assign is_close  = (pop_item.cls == bfrv_pkg::CLS_CLOSE);
   assign pop_ready = !is_close || !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;
   assign csr_ready = 1'b1;
   assign close_len = open_length_ff + LW'(1);

   always_comb begin
      logic [PW:0]   p;
      logic [PW:0]   klen;
      for (int k = 0; k < KC; k++) begin
         klen = bfrv_pkg::key_len(bfrv_pkg::KEY_IDX_W'(k));
         p    = {1'b0, prog_ff[k]};
         feed_found[k] = found_ff[k];
         if (p >= klen) begin
            p = '0;
         end
         if (bfrv_pkg::key_char(bfrv_pkg::KEY_IDX_W'(k), p[PW-1:0]) == pop_item.data) begin
            p = p + (PW+1)'(1);
            if (p == klen) begin
               feed_found[k] = 1'b1;
               p = '0;
            end
         end else begin
            p = (pop_item.data == bfrv_pkg::CHAR_QUOTE) ? (PW+1)'(1) : '0;
         end
         feed_prog[k] = p[PW-1:0];
      end
   end

   always_comb begin
      open_length_in = open_length_ff;
      prog_in        = prog_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_len_in     = rsp_len_ff;
      rsp_status_in  = rsp_status_ff;
      if (do_pop) begin
         case (pop_item.cls)
            bfrv_pkg::CLS_BAD: begin
               open_length_in = '0;
               prog_in        = '{default: '0};
               found_in       = '0;
            end
            bfrv_pkg::CLS_OPEN: begin
               open_length_in = LW'(1);
               prog_in        = '{default: '0};
               found_in       = '0;
            end
            bfrv_pkg::CLS_CLOSE: begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = close_len;
               if (close_len < min_len_ff) begin
                  rsp_status_in = bfrv_pkg::STATUS_SHORT;
               end else if (open_length_ff == '0) begin
                  rsp_status_in = bfrv_pkg::STATUS_NO_OPEN;
               end else if (!(&found_ff)) begin
                  rsp_status_in = bfrv_pkg::STATUS_MISS_KEY;
               end else begin
                  rsp_status_in = bfrv_pkg::STATUS_OK;
               end
               open_length_in = '0;
               prog_in        = '{default: '0};
               found_in       = '0;
            end
            default: begin
               if (open_length_ff != '0) begin
                  if (open_length_ff > max_len_ff ||
                      open_length_ff >= bfrv_pkg::LEN_HARD_CAP) begin
                     open_length_in = '0;
                     prog_in        = '{default: '0};
                     found_in       = '0;
                  end else begin
                     open_length_in = open_length_ff + LW'(1);
                     prog_in        = feed_prog;
                     found_in       = feed_found;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff     <= bfrv_pkg::MIN_LEN_RESET;
         max_len_ff     <= bfrv_pkg::MAX_LEN_RESET;
         open_length_ff <= '0;
         prog_ff        <= '{default: '0};
         found_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bfrv_pkg::CSR_MIN_LEN: min_len_ff <= csr_wdata;
               bfrv_pkg::CSR_MAX_LEN: max_len_ff <= csr_wdata;
               default: ;
            endcase
         end
         open_length_ff <= open_length_in;
         prog_ff        <= prog_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_valid  = (rsp_status_ff == bfrv_pkg::STATUS_OK);

   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      open_length_ff <= bfrv_pkg::LEN_HARD_CAP)
      else $error("open frame length beyond hard cap");

   a_close_slot: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && do_pop && is_close) |-> (!rsp_valid_ff || rsp_ready))
      else $error("close transaction taken while result slot is occupied");

   a_open_restart: assert property (@(posedge clock) disable iff (reset)
      (do_pop && pop_item.cls == bfrv_pkg::CLS_OPEN) |=>
         (open_length_ff == LW'(1) && found_ff == '0))
      else $error("opening brace did not restart the frame");

   a_close_ends: assert property (@(posedge clock) disable iff (reset)
      (do_pop && is_close) |=> (rsp_valid_ff && open_length_ff == '0 && found_ff == '0))
      else $error("closing brace did not end the frame");

   a_no_open_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bfrv_pkg::STATUS_NO_OPEN) |-> (rsp_len_ff == LW'(1)))
      else $error("lone closing brace with length other than one");

endmodule
